### rtl/ptit_pkg.sv
// Shared types and constants of the point-in-triangle test unit.
package ptit_pkg;

  localparam int COORD_WIDTH = 12;
  localparam int EDGE_W      = COORD_WIDTH + 1;
  localparam int DOT_W       = 2 * EDGE_W + 2;
  localparam int VAL_W       = 2 * DOT_W + 1;
  localparam int WSAT_BITS   = 20;
  localparam int WGT_W       = WSAT_BITS + 2;
  localparam int TOL_W       = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_TOL = CFG_ADDR_W'(0);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] pt_x;
    logic signed [COORD_WIDTH-1:0] pt_y;
    logic signed [COORD_WIDTH-1:0] pt_z;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic is_inside;
    logic degenerate;
    logic cache_hit;
  } out_item_t;

  typedef struct packed {
    logic en;
    logic first;
    logic neg;
  } mac_ctl_t;

endpackage

### rtl/ptit_mac.sv
// Shared signed multiply-accumulate unit.
module ptit_mac
  import ptit_pkg::*;
(
  input  logic                    clk,
  input  mac_ctl_t                ctl,
  input  logic signed [DOT_W-1:0] op_a,
  input  logic signed [DOT_W-1:0] op_b,
  output logic signed [VAL_W-1:0] acc_nxt
);

  logic signed [VAL_W-1:0]   acc_r;
  logic signed [2*DOT_W-1:0] prod;
  logic signed [VAL_W-1:0]   prod_x;
  logic signed [VAL_W-1:0]   base;

  assign prod   = op_a * op_b;
  assign prod_x = VAL_W'(prod);
  assign base   = ctl.first ? '0 : acc_r;
  assign acc_nxt = ctl.neg ? (base - prod_x) : (base + prod_x);

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

### rtl/ptit_div.sv
// Bit-serial saturating signed divider for the barycentric weights.
module ptit_div
  import ptit_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] num,
  input  logic signed [VAL_W-1:0] den,
  output logic                    done,
  output logic signed [WGT_W-1:0] weight
);

  localparam int SH    = WSAT_BITS - FRAC_BITS;
  localparam int QW    = WSAT_BITS + 1;
  localparam int CNT_W = $clog2(WSAT_BITS);

  logic [VAL_W-1:0]           n_mag, d_mag, rem0;
  logic [VAL_W+FRAC_BITS-1:0] n_ext;
  logic [VAL_W:0]             trial;
  logic                       ge;

  logic                 busy_r, done_r, sat_r, neg_r;
  logic [VAL_W-1:0]     rem_r, d_r;
  logic [WSAT_BITS-1:0] low_r;
  logic [QW-1:0]        q_r;
  logic [CNT_W-1:0]     cnt_r;

  assign n_mag = num[VAL_W-1] ? VAL_W'(-num) : VAL_W'(num);
  assign d_mag = den[VAL_W-1] ? VAL_W'(-den) : VAL_W'(den);
  assign n_ext = {n_mag, {FRAC_BITS{1'b0}}};
  assign rem0  = n_mag >> SH;
  assign trial = {rem_r, low_r[WSAT_BITS-1]};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (sat_r || cnt_r == CNT_W'(WSAT_BITS - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem0;
      d_r   <= d_mag;
      low_r <= n_ext[WSAT_BITS-1:0];
      sat_r <= rem0 >= d_mag;
      neg_r <= num[VAL_W-1] ^ den[VAL_W-1];
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (sat_r) begin
        q_r <= QW'(1) << WSAT_BITS;
      end else begin
        rem_r <= ge ? VAL_W'(trial - {1'b0, d_r}) : VAL_W'(trial);
        q_r   <= {q_r[QW-2:0], ge};
        low_r <= low_r << 1;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  assign done   = done_r;
  assign weight = neg_r ? -$signed(WGT_W'(q_r)) : $signed(WGT_W'(q_r));

endmodule

### rtl/point_in_triangle_test_unit.sv
// Point-in-triangle test unit: barycentric weights by a shared MAC and a serial divider.
//
// Each item carries a query point and three triangle vertices; the block returns one
// result item telling whether the point's barycentric weights lie inside the tolerance
// band, whether the triangle is degenerate (zero Gram determinant), and whether the
// triangle setup was reused from the previous item. All work runs through one signed
// multiply-accumulate unit and one bit-serial divider, one item at a time: in_stall is
// high from acceptance until the result has been placed in the output register. An item
// whose vertices match the cached triangle skips the triangle setup steps of the MAC
// program; a non-degenerate triangle then adds two divisions (one quotient bit a cycle,
// ending early when the quotient saturates), and the FIN state hands over the result.
// edge_tolerance sits at byte address 0 of the APB-style port and should be written
// only while the block is idle.
module point_in_triangle_test_unit
  import ptit_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int STEP_W     = 5;
  localparam int STEP_HIT   = 11;
  localparam int STEP_LAST  = 20;
  localparam int GAM_W      = WSAT_BITS + 4;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CALC = 5'b00010,
    ST_DIVA = 5'b00100,
    ST_DIVB = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_D00, DST_D01, DST_D11, DST_DET, DST_D20, DST_D21, DST_NA, DST_NB
  } dest_t;

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [TOL_W-1:0]  tol_r;
  logic              setup_valid_r;
  logic              hit_r;
  logic              in_acc, hit, cfg_wr;

  // cached triangle
  logic signed [COORD_WIDTH-1:0] va_x_r, va_y_r, va_z_r, vb_x_r, vb_y_r, vb_z_r;
  logic signed [COORD_WIDTH-1:0] vc_x_r, vc_y_r, vc_z_r;
  logic signed [EDGE_W-1:0] e0x_r, e0y_r, e0z_r, e1x_r, e1y_r, e1z_r;
  logic signed [EDGE_W-1:0] vx_r, vy_r, vz_r;
  logic signed [DOT_W-1:0]  d00_r, d01_r, d11_r, d20_r, d21_r;
  logic signed [VAL_W-1:0]  det_r, na_r, nb_r;

  mac_ctl_t                mac_ctl;
  logic signed [DOT_W-1:0] op_a, op_b;
  logic signed [VAL_W-1:0] acc_nxt;
  dest_t                   dest;

  logic                    div_start, div_done;
  logic signed [VAL_W-1:0] div_num;
  logic signed [WGT_W-1:0] div_w, alpha_r;
  out_item_t               res_r;
  out_item_t               out_data_r;
  logic                    out_valid_r;

  logic signed [GAM_W-1:0] one_w, tol_x, gam;
  logic                    in_band;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == REG_EDGE_TOL) ? CFG_DATA_W'(tol_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr && cfg_paddr == REG_EDGE_TOL) begin
      tol_r <= cfg_pwdata[TOL_W-1:0];
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  assign hit = setup_valid_r &&
               in_data.a_x == va_x_r && in_data.a_y == va_y_r && in_data.a_z == va_z_r &&
               in_data.b_x == vb_x_r && in_data.b_y == vb_y_r && in_data.b_z == vb_z_r &&
               in_data.c_x == vc_x_r && in_data.c_y == vc_y_r && in_data.c_z == vc_z_r;

  // capture item; rebuild the edges only on a miss
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hit_r <= hit;
      vx_r  <= EDGE_W'(in_data.pt_x) - EDGE_W'(in_data.a_x);
      vy_r  <= EDGE_W'(in_data.pt_y) - EDGE_W'(in_data.a_y);
      vz_r  <= EDGE_W'(in_data.pt_z) - EDGE_W'(in_data.a_z);
      if (!hit) begin
        va_x_r <= in_data.a_x;
        va_y_r <= in_data.a_y;
        va_z_r <= in_data.a_z;
        vb_x_r <= in_data.b_x;
        vb_y_r <= in_data.b_y;
        vb_z_r <= in_data.b_z;
        vc_x_r <= in_data.c_x;
        vc_y_r <= in_data.c_y;
        vc_z_r <= in_data.c_z;
        e0x_r  <= EDGE_W'(in_data.b_x) - EDGE_W'(in_data.a_x);
        e0y_r  <= EDGE_W'(in_data.b_y) - EDGE_W'(in_data.a_y);
        e0z_r  <= EDGE_W'(in_data.b_z) - EDGE_W'(in_data.a_z);
        e1x_r  <= EDGE_W'(in_data.c_x) - EDGE_W'(in_data.a_x);
        e1y_r  <= EDGE_W'(in_data.c_y) - EDGE_W'(in_data.a_y);
        e1z_r  <= EDGE_W'(in_data.c_z) - EDGE_W'(in_data.a_z);
      end
    end
  end

  // MAC micro-program: triangle setup first (miss only), then the per-point terms
  always_comb begin
    op_a          = '0;
    op_b          = '0;
    mac_ctl.en    = (state_r == ST_CALC);
    mac_ctl.first = 1'b0;
    mac_ctl.neg   = 1'b0;
    dest          = DST_NONE;
    case (step_r)
      5'd0:  begin op_a = DOT_W'(e0x_r); op_b = DOT_W'(e0x_r); mac_ctl.first = 1'b1; end
      5'd1:  begin op_a = DOT_W'(e0y_r); op_b = DOT_W'(e0y_r); end
      5'd2:  begin op_a = DOT_W'(e0z_r); op_b = DOT_W'(e0z_r); dest = DST_D00; end
      5'd3:  begin op_a = DOT_W'(e0x_r); op_b = DOT_W'(e1x_r); mac_ctl.first = 1'b1; end
      5'd4:  begin op_a = DOT_W'(e0y_r); op_b = DOT_W'(e1y_r); end
      5'd5:  begin op_a = DOT_W'(e0z_r); op_b = DOT_W'(e1z_r); dest = DST_D01; end
      5'd6:  begin op_a = DOT_W'(e1x_r); op_b = DOT_W'(e1x_r); mac_ctl.first = 1'b1; end
      5'd7:  begin op_a = DOT_W'(e1y_r); op_b = DOT_W'(e1y_r); end
      5'd8:  begin op_a = DOT_W'(e1z_r); op_b = DOT_W'(e1z_r); dest = DST_D11; end
      5'd9:  begin op_a = d00_r; op_b = d11_r; mac_ctl.first = 1'b1; end
      5'd10: begin op_a = d01_r; op_b = d01_r; mac_ctl.neg = 1'b1; dest = DST_DET; end
      5'd11: begin op_a = DOT_W'(vx_r); op_b = DOT_W'(e0x_r); mac_ctl.first = 1'b1; end
      5'd12: begin op_a = DOT_W'(vy_r); op_b = DOT_W'(e0y_r); end
      5'd13: begin op_a = DOT_W'(vz_r); op_b = DOT_W'(e0z_r); dest = DST_D20; end
      5'd14: begin op_a = DOT_W'(vx_r); op_b = DOT_W'(e1x_r); mac_ctl.first = 1'b1; end
      5'd15: begin op_a = DOT_W'(vy_r); op_b = DOT_W'(e1y_r); end
      5'd16: begin op_a = DOT_W'(vz_r); op_b = DOT_W'(e1z_r); dest = DST_D21; end
      5'd17: begin op_a = d11_r; op_b = d20_r; mac_ctl.first = 1'b1; end
      5'd18: begin op_a = d01_r; op_b = d21_r; mac_ctl.neg = 1'b1; dest = DST_NA; end
      5'd19: begin op_a = d00_r; op_b = d21_r; mac_ctl.first = 1'b1; end
      5'd20: begin op_a = d01_r; op_b = d20_r; mac_ctl.neg = 1'b1; dest = DST_NB; end
      default: begin end
    endcase
  end

  ptit_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc_nxt (acc_nxt)
  );

  always_ff @(posedge clk) begin
    if (mac_ctl.en) begin
      case (dest)
        DST_D00: d00_r <= acc_nxt[DOT_W-1:0];
        DST_D01: d01_r <= acc_nxt[DOT_W-1:0];
        DST_D11: d11_r <= acc_nxt[DOT_W-1:0];
        DST_DET: det_r <= acc_nxt;
        DST_D20: d20_r <= acc_nxt[DOT_W-1:0];
        DST_D21: d21_r <= acc_nxt[DOT_W-1:0];
        DST_NA:  na_r  <= acc_nxt;
        DST_NB:  nb_r  <= acc_nxt;
        default: begin end
      endcase
    end
  end

  // alpha first once the MAC program has finished, beta once alpha is in
  assign div_start = (state_r == ST_CALC && step_r == STEP_W'(STEP_LAST) && det_r != '0) ||
                     (state_r == ST_DIVA && div_done);
  assign div_num   = (state_r == ST_CALC) ? na_r : nb_r;

  ptit_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (det_r),
    .done   (div_done),
    .weight (div_w)
  );

  // band check: gamma comes from one minus alpha minus beta
  assign one_w  = GAM_W'(1) << FRAC_BITS;
  assign tol_x  = $signed(GAM_W'(tol_r));
  assign gam    = one_w - GAM_W'(alpha_r) - GAM_W'(div_w);
  assign in_band = GAM_W'(alpha_r) >= -tol_x && GAM_W'(alpha_r) <= one_w + tol_x &&
                   GAM_W'(div_w) >= -tol_x && GAM_W'(div_w) <= one_w + tol_x &&
                   gam >= -tol_x && gam <= one_w + tol_x;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_CALC;
      ST_CALC: begin
        if (step_r == STEP_W'(STEP_LAST)) begin
          state_nxt = (det_r == '0) ? ST_FIN : ST_DIVA;
        end
      end
      ST_DIVA: if (div_done) state_nxt = ST_DIVB;
      ST_DIVB: if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      setup_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        step_r        <= hit ? STEP_W'(STEP_HIT) : '0;
        setup_valid_r <= 1'b1;
      end else if (state_r == ST_CALC) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DIVA && div_done) begin
      alpha_r <= div_w;
    end
    if (state_r == ST_CALC && step_r == STEP_W'(STEP_LAST) && det_r == '0) begin
      res_r <= '{is_inside: 1'b0, degenerate: 1'b1, cache_hit: hit_r};
    end else if (state_r == ST_DIVB && div_done) begin
      res_r <= '{is_inside: in_band, degenerate: 1'b0, cache_hit: hit_r};
    end
    if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
